### rtl/event_code_range_filter_macros.svh
// ----------------------------------------------------------------------------
// event code range filter assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef EVENT_CODE_RANGE_FILTER_MACROS_SVH
`define EVENT_CODE_RANGE_FILTER_MACROS_SVH

// same-cycle implication
`define ECRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("event filter check failed");

// next-cycle implication
`define ECRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("event filter check failed");

`endif

### rtl/ecrf_pkg.sv
// ----------------------------------------------------------------------------
// ecrf_pkg
// types, codes and the rule test shared by the event code range filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecrf_pkg;

   localparam int TYPE_W  = 16;
   localparam int CODE_W  = 16;
   localparam int VALUE_W = 32;
   localparam int MODE_W  = 2;

   localparam int RULE_SLOTS_DEFAULT = 16;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_ADD   = 1'b1;

   localparam logic [MODE_W-1:0] MODE_ANY    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RANGE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [TYPE_W-1:0] type_id;
      logic [MODE_W-1:0] mode;
      logic [CODE_W-1:0] low;
      logic [CODE_W-1:0] high;
   } rule_entry_type;

   function automatic logic rule_passes(input rule_entry_type rule,
                                        input logic [TYPE_W-1:0] ev_type,
                                        input logic [CODE_W-1:0] ev_code);
      logic pass;
      pass = 1'b0;
      if (rule.type_id == ev_type) begin
         case (rule.mode)
            MODE_ANY:   pass = 1'b1;
            MODE_EXACT: pass = (rule.low == ev_code);
            MODE_RANGE: pass = (ev_code >= rule.low) && (ev_code <= rule.high);
            default:    pass = 1'b0;
         endcase
      end
      return pass;
   endfunction

endpackage

### rtl/ecrf_if.sv
// ----------------------------------------------------------------------------
// ecrf channel interfaces
// valid/ready channels for items, results and the control register write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ecrf_req_if import ecrf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [TYPE_W-1:0]         item_type;
   logic [CODE_W-1:0]         item_code;
   logic signed [VALUE_W-1:0] item_value;
   logic [MODE_W-1:0]         rule_mode;
   logic [CODE_W-1:0]         range_low;
   logic [CODE_W-1:0]         range_high;

   modport source (output valid, kind, item_type, item_code, item_value, rule_mode,
                   range_low, range_high, input ready);
   modport sink (input valid, kind, item_type, item_code, item_value, rule_mode,
                 range_low, range_high, output ready);
endinterface

interface ecrf_rsp_if import ecrf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      forwarded;
   logic [TYPE_W-1:0]         out_type;
   logic [CODE_W-1:0]         out_code;
   logic signed [VALUE_W-1:0] out_value;
   logic                      table_full;

   modport source (output valid, forwarded, out_type, out_code, out_value, table_full,
                   input ready);
   modport sink (input valid, forwarded, out_type, out_code, out_value, table_full,
                 output ready);
endinterface

interface ecrf_csr_if ();
   logic valid;
   logic ready;
   logic invert_match;

   modport source (output valid, invert_match, input ready);
   modport sink (input valid, invert_match, output ready);
endinterface

### rtl/event_code_range_filter.sv
// ----------------------------------------------------------------------------
// event_code_range_filter
// filters events against a rule table held in a one-write, one-read rule memory
// ----------------------------------------------------------------------------
// req_chan carries items: kind 0 is an event, kind 1 adds a rule. rsp_chan
// returns exactly one result item for every request item, in order.
// csr_chan writes invert_match and is always ready. The user must write it
// only while idle; the block itself does not enforce this.
// An add item is written to the rule memory in its accept cycle; its result
// then passes through the finish state to the output register. An event item
// scans the stored rules one per cycle through the registered-read rule
// memory, in the scan, last and finish states (straight to finish with an
// empty table). A new item is accepted once the previous one has been moved
// to the output register, so the block works on one item at a time.
//
// Reset empties the rule table, clears invert_match and drops any pending
// result. While the receiver stalls, the finished result waits in the output
// register; the next item is accepted and worked on, and waits for that
// register before it completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "event_code_range_filter_macros.svh"

module event_code_range_filter import ecrf_pkg::*; #(
   parameter int RULE_SLOTS = RULE_SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ecrf_req_if.sink   req_chan,
   ecrf_rsp_if.source rsp_chan,
   ecrf_csr_if.sink   csr_chan
);

   localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CNT_W = $clog2(RULE_SLOTS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_LAST   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic                      invert_ff;
   logic                      hit_ff;
   logic                      rd_valid_ff;
   rule_entry_type            rd_rule_ff;
   rule_entry_type            rule_mem [RULE_SLOTS];

   logic                      kind_ff;
   logic                      full_ff;
   logic [TYPE_W-1:0]         type_ff;
   logic [CODE_W-1:0]         code_ff;
   logic signed [VALUE_W-1:0] value_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_fwd_ff;
   logic                      rsp_full_ff;
   logic [TYPE_W-1:0]         rsp_type_ff;
   logic [CODE_W-1:0]         rsp_code_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;

   logic           req_acc;
   logic           table_is_full;
   logic           add_ok;
   logic           out_free;
   logic           finish_go;
   logic           last_idx;
   logic           fwd_in;
   rule_entry_type new_rule;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign table_is_full  = (count_ff == CNT_W'(RULE_SLOTS));
   assign add_ok         = req_acc && (req_chan.kind == KIND_ADD)
                           && (req_chan.rule_mode != MODE_UNUSED) && !table_is_full;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign finish_go      = (state_ff == ST_FINISH) && out_free;
   assign last_idx       = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign fwd_in         = (kind_ff == KIND_EVENT) && (hit_ff != invert_ff);

   assign csr_chan.ready = 1'b1;

   always_comb begin
      new_rule.type_id = req_chan.item_type;
      new_rule.mode    = req_chan.rule_mode;
      new_rule.low     = '0;
      new_rule.high    = '0;
      if (req_chan.rule_mode == MODE_EXACT) begin
         new_rule.low  = req_chan.item_code;
         new_rule.high = req_chan.item_code;
      end else if (req_chan.rule_mode == MODE_RANGE) begin
         new_rule.low  = req_chan.range_low;
         new_rule.high = req_chan.range_high;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.kind == KIND_ADD || count_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (last_idx) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         invert_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_SCAN);
         if (add_ok) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (csr_chan.valid && csr_chan.ready) begin
            invert_ff <= csr_chan.invert_match;
         end
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // rule memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (add_ok) begin
         rule_mem[count_ff[IDX_W-1:0]] <= new_rule;
      end
   end

   always_ff @(posedge clock) begin
      rd_rule_ff <= rule_mem[idx_ff];
   end

   // item capture and rule scan
   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff  <= req_chan.kind;
         type_ff  <= req_chan.item_type;
         code_ff  <= req_chan.item_code;
         value_ff <= req_chan.item_value;
         full_ff  <= (req_chan.kind == KIND_ADD) && (req_chan.rule_mode != MODE_UNUSED)
                     && table_is_full;
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_SCAN && !last_idx) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (rd_valid_ff && rule_passes(rd_rule_ff, type_ff, code_ff)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_fwd_ff   <= fwd_in;
         rsp_full_ff  <= full_ff;
         rsp_type_ff  <= fwd_in ? type_ff : '0;
         rsp_code_ff  <= fwd_in ? code_ff : '0;
         rsp_value_ff <= fwd_in ? value_ff : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.forwarded  = rsp_fwd_ff;
   assign rsp_chan.table_full = rsp_full_ff;
   assign rsp_chan.out_type   = rsp_type_ff;
   assign rsp_chan.out_code   = rsp_code_ff;
   assign rsp_chan.out_value  = rsp_value_ff;

   `ECRF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(RULE_SLOTS))
   `ECRF_ASSERT_NOW(a_full_not_fwd, clock, reset, rsp_valid_ff && rsp_full_ff, !rsp_fwd_ff)
   `ECRF_ASSERT_NEXT(a_full_keeps_count, clock, reset, req_acc && table_is_full, count_ff == $past(count_ff))
   `ECRF_ASSERT_NEXT(a_scan_reads_stored, clock, reset, state_ff == ST_SCAN, CNT_W'($past(idx_ff)) < count_ff)

endmodule
